// ===== rtl/hpp_pkg.sv =====
// hpp_pkg: shared types and constants of the heater power profile block
// widths, operation codes, segment limits and reciprocal constants
// no dependencies
package hpp_pkg;

    localparam int USER_W  = 12;
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 12;
    localparam int RES_W   = 16;
    localparam int POWER_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int SLOPE_W = 11;
    localparam int PROD_W  = USER_W + SLOPE_W;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_USER_POWER    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_STRENGTH_MODE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_AUTO_TAPER    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_POWER_LIMIT   = 2'd3;

    // strength modes; the spare code behaves as soft
    localparam logic [MODE_W-1:0] MODE_SOFT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    // request kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // setpoint selection codes
    localparam logic [2:0] OP_HOLD  = 3'd0;
    localparam logic [2:0] OP_FIXED = 3'd1;
    localparam logic [2:0] OP_TAPER = 3'd2;
    localparam logic [2:0] OP_RAMP  = 3'd3;
    localparam logic [2:0] OP_START = 3'd4;

    // low-load test limits
    localparam logic [USER_W-1:0] LOW_USER_MAX = 12'd1000;
    localparam logic [RES_W-1:0]  LOW_RES_MAX  = 16'd800;

    // segment boundaries in 10 ms units
    localparam logic [TIME_W-1:0] T_TAPER_END   = 12'd300;
    localparam logic [TIME_W-1:0] T_TAPER_START = 12'd130;
    localparam logic [TIME_W-1:0] T_RAMP_END    = 12'd60;
    localparam logic [TIME_W-1:0] T_RAMP_START  = 12'd30;
    localparam logic [TIME_W-1:0] T_LOW_X10     = 12'd20;
    localparam logic [TIME_W-1:0] T_LOW_X14     = 12'd10;

    // slope bases of the taper and ramp segments
    localparam logic [TIME_W-1:0] TAPER_BASE = 12'd1960;
    localparam logic [TIME_W-1:0] RAMP_BASE  = 12'd540;

    // x/170 = (x * ceil(2^31/170)) >> 31, x/30 = (x * ceil(2^26/30)) >> 26
    localparam int RECIP_W     = 24;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam int TAPER_SHIFT = 31;
    localparam int RAMP_SHIFT  = 26;
    localparam logic [RECIP_W-1:0] TAPER_RECIP = 24'd12632257;
    localparam logic [RECIP_W-1:0] RAMP_RECIP  = 24'd2236963;

    typedef struct packed {
        logic [2:0]         op;
        logic [POWER_W-1:0] fixed;
        logic [POWER_W-1:0] cap;
        logic [PROD_W-1:0]  prod;
    } seg_t;

endpackage

// ===== rtl/hpp_segment.sv =====
// hpp_segment: picks the boost or the puff-time segment of one request
// and forms the user power products for the later divide stage
// depends on hpp_pkg
module hpp_segment (
    input  logic                        func,
    input  logic [hpp_pkg::TIME_W-1:0]  puff_time,
    input  logic [hpp_pkg::RES_W-1:0]   load_resistance,
    input  logic [hpp_pkg::POWER_W-1:0] cap_in,
    input  logic [hpp_pkg::USER_W-1:0]  user_power,
    input  logic [hpp_pkg::MODE_W-1:0]  strength_mode,
    input  logic                        auto_taper,
    output hpp_pkg::seg_t               seg
);
    import hpp_pkg::*;

    logic               low_load;
    logic [POWER_W-1:0] x8;
    logic [POWER_W-1:0] x10;
    logic [POWER_W-1:0] x14;
    logic [POWER_W-1:0] x16;
    logic [POWER_W-1:0] boost;
    logic [TIME_W-1:0]  taper_full;
    logic [TIME_W-1:0]  ramp_full;
    logic [SLOPE_W-1:0] slope;

    assign low_load = (user_power <= LOW_USER_MAX) && (load_resistance <= LOW_RES_MAX);

    // fixed multiples by shift and add, all below 2^16 for a 12-bit user power
    assign x8  = {1'b0, user_power, 3'b000};
    assign x16 = {user_power, 4'b0000};
    assign x10 = x8 + {3'b000, user_power, 1'b0};
    assign x14 = x16 - {3'b000, user_power, 1'b0};

    assign taper_full = TAPER_BASE - {puff_time[TIME_W-2:0], 1'b0};
    assign ramp_full  = RAMP_BASE - {puff_time[TIME_W-3:0], 2'b00};

    always_comb
    begin
        boost = x10;
        case (strength_mode)
            MODE_HIGH:   boost = x14;
            MODE_NORMAL: boost = low_load ? x16 : x14;
            default:     boost = x10;
        endcase
    end

    always_comb
    begin
        seg.op    = OP_HOLD;
        seg.fixed = x10;
        seg.cap   = cap_in;
        slope     = '0;
        if (func == FUNC_START)
        begin
            seg.op    = OP_START;
            seg.cap   = (boost < cap_in) ? boost : cap_in;
            seg.fixed = (strength_mode == MODE_SOFT || strength_mode == MODE_SPARE) ? x8 : boost;
        end
        else
        begin
            case (strength_mode)
                MODE_HIGH:
                begin
                    if (auto_taper && puff_time > T_TAPER_END)
                    begin
                        seg.op    = OP_FIXED;
                        seg.fixed = x8;
                    end
                    else if (auto_taper && puff_time > T_TAPER_START)
                    begin
                        seg.op = OP_TAPER;
                        slope  = taper_full[SLOPE_W-1:0];
                    end
                    else if (puff_time > T_RAMP_END)
                    begin
                        seg.op = OP_FIXED;
                    end
                    else if (puff_time > T_RAMP_START)
                    begin
                        seg.op = OP_RAMP;
                        slope  = ramp_full[SLOPE_W-1:0];
                    end
                end
                MODE_NORMAL:
                begin
                    if (auto_taper && puff_time >= T_TAPER_END)
                    begin
                        seg.op    = OP_FIXED;
                        seg.fixed = x8;
                    end
                    else if (auto_taper && puff_time >= T_TAPER_START)
                    begin
                        seg.op = OP_TAPER;
                        slope  = taper_full[SLOPE_W-1:0];
                    end
                    else if (low_load)
                    begin
                        if (puff_time >= T_LOW_X10)
                        begin
                            seg.op = OP_FIXED;
                        end
                        else if (puff_time >= T_LOW_X14)
                        begin
                            seg.op    = OP_FIXED;
                            seg.fixed = x14;
                        end
                    end
                    else if (puff_time >= T_RAMP_START)
                    begin
                        seg.op = OP_FIXED;
                    end
                end
                default:
                begin
                    if (auto_taper && puff_time > T_TAPER_END)
                    begin
                        seg.op    = OP_FIXED;
                        seg.fixed = x8;
                    end
                    else if (auto_taper && puff_time > T_TAPER_START)
                    begin
                        seg.op = OP_TAPER;
                        slope  = taper_full[SLOPE_W-1:0];
                    end
                    else if (puff_time >= T_RAMP_START)
                    begin
                        seg.op = OP_FIXED;
                    end
                end
            endcase
        end
        seg.prod = PROD_W'(user_power) * PROD_W'(slope);
    end

endmodule

// ===== rtl/heater_power_profile.sv =====
// heater_power_profile: top level of the heater power setpoint generator
// three-stage pipeline around hpp_segment with the reciprocal divide stage
// depends on hpp_pkg and hpp_segment
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   cfg     | cfg_we             | cfg_index, cfg_data
//   in      | in_valid, in_stall | func, puff_time, load_resistance, cap_in
//   out     | out_valid,out_stall| setpoint, power_cap
//
// one request enters per cycle while in_stall is low
// each result passes through the input register, the segment product register and the
// reciprocal multiply into the result register
// reset clears the valid flags, the held setpoint and loads register defaults
// a stalled result holds the pipe; in_stall rises only when all three stages are full
module heater_power_profile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [hpp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hpp_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [hpp_pkg::TIME_W-1:0]  puff_time,
    input  logic [hpp_pkg::RES_W-1:0]   load_resistance,
    input  logic [hpp_pkg::POWER_W-1:0] cap_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hpp_pkg::POWER_W-1:0] setpoint,
    output logic [hpp_pkg::POWER_W-1:0] power_cap
);
    import hpp_pkg::*;

    // configuration registers
    logic [USER_W-1:0]  user_power_reg;
    logic [MODE_W-1:0]  strength_mode_reg;
    logic               auto_taper_reg;
    logic [POWER_W-1:0] power_limit_reg;

    // stage 1: request register
    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic [TIME_W-1:0]  s1_time_reg;
    logic [RES_W-1:0]   s1_res_reg;
    logic [POWER_W-1:0] s1_cap_reg;

    // stage 2: segment choice and product
    logic               s2_valid_reg;
    seg_t               s2_seg_reg;
    seg_t               seg;

    // stage 3: result register and held setpoint
    logic               s3_valid_reg;
    logic [POWER_W-1:0] setpoint_reg;
    logic [POWER_W-1:0] power_cap_reg;
    logic [POWER_W-1:0] held_reg;
    logic [POWER_W-1:0] held_next;

    logic               ready1;
    logic               ready2;
    logic               ready3;

    logic [RECIP_W-1:0] recip_sel;
    logic [QPROD_W-1:0] qprod;
    logic [POWER_W-1:0] quotient;
    logic [POWER_W-1:0] tick_value;

    // each stage moves when the one after it is empty or moving
    assign ready3   = !s3_valid_reg || !out_stall;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign in_stall = !ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_power_reg    <= 12'd50;
            strength_mode_reg <= MODE_NORMAL;
            auto_taper_reg    <= 1'b0;
            power_limit_reg   <= 16'd20000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_USER_POWER:    user_power_reg    <= cfg_data[USER_W-1:0];
                CFG_STRENGTH_MODE: strength_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_AUTO_TAPER:    auto_taper_reg    <= cfg_data[0];
                CFG_POWER_LIMIT:   power_limit_reg   <= cfg_data[POWER_W-1:0];
                default:           power_limit_reg   <= power_limit_reg;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ready1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            s1_func_reg <= func;
            s1_time_reg <= puff_time;
            s1_res_reg  <= load_resistance;
            s1_cap_reg  <= cap_in;
        end
    end

    hpp_segment u_segment (
        .func            (s1_func_reg),
        .puff_time       (s1_time_reg),
        .load_resistance (s1_res_reg),
        .cap_in          (s1_cap_reg),
        .user_power      (user_power_reg),
        .strength_mode   (strength_mode_reg),
        .auto_taper      (auto_taper_reg),
        .seg             (seg)
    );

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ready2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            s2_seg_reg <= seg;
        end
    end

    // divide by 170 or 30 through one shared reciprocal multiply
    assign recip_sel = (s2_seg_reg.op == OP_TAPER) ? TAPER_RECIP : RAMP_RECIP;
    assign qprod     = QPROD_W'(s2_seg_reg.prod) * QPROD_W'(recip_sel);
    assign quotient  = (s2_seg_reg.op == OP_TAPER)
                     ? qprod[TAPER_SHIFT +: POWER_W]
                     : qprod[RAMP_SHIFT +: POWER_W];

    always_comb
    begin
        tick_value = held_reg;
        unique case (s2_seg_reg.op)
            OP_FIXED: tick_value = s2_seg_reg.fixed;
            OP_TAPER: tick_value = quotient;
            OP_RAMP:  tick_value = quotient;
            default:  tick_value = held_reg;
        endcase
    end

    // ticks clamp at the limit, gaps included; start skips the clamp
    always_comb
    begin
        if (s2_seg_reg.op == OP_START)
        begin
            held_next = s2_seg_reg.fixed;
        end
        else if (tick_value > power_limit_reg)
        begin
            held_next = power_limit_reg;
        end
        else
        begin
            held_next = tick_value;
        end
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            held_reg     <= '0;
        end
        else if (ready3)
        begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            setpoint_reg  <= held_next;
            power_cap_reg <= s2_seg_reg.cap;
        end
    end

    assign out_valid = s3_valid_reg;
    assign setpoint  = setpoint_reg;
    assign power_cap = power_cap_reg;

`ifndef SYNTHESIS
    // back-pressure only when every stage holds a request
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_stall))
        else $error("input stalled with an empty stage");

    // the shown result is always the held setpoint
    a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (setpoint_reg == held_reg))
        else $error("result setpoint differs from held setpoint");

    // a blocked request in stage 1 is not dropped
    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !ready2) |=> s1_valid_reg)
        else $error("stage 1 request lost while blocked");

    // a tick result never exceeds the limit
    a_tick_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_seg_reg.op != OP_START) |-> (held_next <= power_limit_reg))
        else $error("tick setpoint above power limit");
`endif

endmodule
